FILE: rtl/averaged_level_alarm_top_macros.svh
// ----------------------------------------------------------------------------
// averaged_level_alarm_top_macros
// Assertion macros used by the port-level checker of the averaged level alarm.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_LEVEL_ALARM_TOP_MACROS_SVH
`define AVERAGED_LEVEL_ALARM_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ALA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ala check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ALA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ala check failed: next-cycle rule");

`endif

FILE: rtl/ala_pkg.sv
// ----------------------------------------------------------------------------
// ala_pkg
// Types, widths and constants of the averaged level alarm.
// ----------------------------------------------------------------------------
package ala_pkg;

	// Field widths
	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 12;
	localparam int ENABLE_W = 3;

	// Ring geometry
	localparam int RING_DEPTH = 8;
	localparam int RING_LOG   = $clog2(RING_DEPTH);
	localparam int SLOT_W     = (RING_DEPTH > 1) ? RING_LOG : 1;
	localparam int TOTAL_W    = SAMPLE_W + RING_LOG;

	// Divide by the ring depth as a multiply by a rounded-up reciprocal
	localparam int DIV_SHIFT = TOTAL_W + RING_LOG;
	localparam int RECIP_W   = TOTAL_W + 1;
	localparam int PROD_W    = TOTAL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

	// Register reset values
	localparam logic [LEVEL_W-1:0]  WARNING_RST  = 12'd500;
	localparam logic [LEVEL_W-1:0]  ALERT_RST    = 12'd1500;
	localparam logic [LEVEL_W-1:0]  CRITICAL_RST = 12'd2500;
	localparam logic [ENABLE_W-1:0] ENABLE_RST   = 3'd7;

	// Enable bit positions
	localparam int EN_RELAY  = 0;
	localparam int EN_LAMP   = 1;
	localparam int EN_BUZZER = 2;

	// Stream widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	typedef enum logic [1:0] {
		REG_WARNING  = 2'd0,
		REG_ALERT    = 2'd1,
		REG_CRITICAL = 2'd2,
		REG_ENABLES  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LVL_SAFE     = 2'd0,
		LVL_WARNING  = 2'd1,
		LVL_ALERT    = 2'd2,
		LVL_CRITICAL = 2'd3
	} level_t;

	// Thresholds and enables handed to the level logic
	typedef struct packed {
		logic [ENABLE_W-1:0] enables;
		logic [LEVEL_W-1:0]  critical;
		logic [LEVEL_W-1:0]  alert;
		logic [LEVEL_W-1:0]  warning;
	} cfg_t;

	// One result beat, average in the lowest bits
	typedef struct packed {
		logic                buzzer_drive;
		logic                lamp_drive;
		logic                relay_drive;
		logic                alarm_active;
		level_t              level;
		logic [SAMPLE_W-1:0] average;
	} result_t;

endpackage

FILE: rtl/ala_ring.sv
// ----------------------------------------------------------------------------
// ala_ring
// Sample ring with running total; gives the truncated average after the
// current sample replaces the oldest one.
// ----------------------------------------------------------------------------
module ala_ring import ala_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] sample,
	output logic [SAMPLE_W-1:0] average
);

	logic [SAMPLE_W-1:0] ring_q [RING_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  total_next;
	logic [SLOT_W-1:0]   slot_next;
	logic [PROD_W-1:0]   prod;

	// Swap the oldest sample for the new one in the total
	assign total_next = total_q - TOTAL_W'(ring_q[slot_q]) + TOTAL_W'(sample);

	// Wrap the write slot at the ring depth
	assign slot_next = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);

	// Divide by the depth through the reciprocal
	assign prod    = PROD_W'(total_next) * PROD_W'(RECIP);
	assign average = prod[DIV_SHIFT +: SAMPLE_W];

	// Advance ring, slot and total once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			slot_q  <= '0;
			total_q <= '0;
		end else if (step) begin
			ring_q[slot_q] <= sample;
			slot_q         <= slot_next;
			total_q        <= total_next;
		end
	end

endmodule

FILE: rtl/ala_judge.sv
// ----------------------------------------------------------------------------
// ala_judge
// Threshold classification, alarm latch and relay, lamp and buzzer levels.
// ----------------------------------------------------------------------------
module ala_judge import ala_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] average,
	input  cfg_t                cfg,
	output result_t             res
);

	logic   latch_q, relay_q, lamp_q, buzzer_q;
	logic   latch_n, relay_n, lamp_n, buzzer_n;
	level_t level;

	// Classify in priority critical, alert, warning
	always_comb begin
		latch_n = latch_q;
		priority if (average >= cfg.critical) begin
			level   = LVL_CRITICAL;
			latch_n = 1'b1;
		end else if (average >= cfg.alert) begin
			level = LVL_ALERT;
		end else if (average >= cfg.warning) begin
			level = LVL_WARNING;
		end else begin
			level   = LVL_SAFE;
			latch_n = 1'b0;
		end
	end

	// Enabled relay, lamp follow the latch; enabled buzzer: off unlatched, on at critical, else toggles; rest hold
	always_comb begin
		relay_n  = cfg.enables[EN_RELAY] ? latch_n : relay_q;
		lamp_n   = cfg.enables[EN_LAMP]  ? latch_n : lamp_q;
		buzzer_n = buzzer_q;
		if (cfg.enables[EN_BUZZER]) begin
			if (!latch_n) begin
				buzzer_n = 1'b0;
			end else if (level == LVL_CRITICAL) begin
				buzzer_n = 1'b1;
			end else begin
				buzzer_n = !buzzer_q;
			end
		end
	end

	assign res = '{buzzer_drive: buzzer_n, lamp_drive: lamp_n, relay_drive: relay_n,
		alarm_active: latch_n, level: level, average: average};

	// Commit latch and drive levels once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q  <= 1'b0;
			relay_q  <= 1'b0;
			lamp_q   <= 1'b0;
			buzzer_q <= 1'b0;
		end else if (step) begin
			latch_q  <= latch_n;
			relay_q  <= relay_n;
			lamp_q   <= lamp_n;
			buzzer_q <= buzzer_n;
		end
	end

endmodule

FILE: rtl/averaged_level_alarm_top.sv
// Path: an accepted sample is held in the input register; its result beat is loaded
// into the result register when that register is free or being taken.
// Throughput: one sample per cycle while the result stream is not stalled; the ring
// total update and the latch and drive update both lie between input and result register.
// Reset: clears the sample ring, running total, write slot, alarm latch and drive
// levels, and loads the thresholds and enables with their defaults; no beat pending.
// ----------------------------------------------------------------------------
// averaged_level_alarm_top
// Moving-average gas level alarm on a sample stream with a result stream.
// ----------------------------------------------------------------------------
module averaged_level_alarm_top import ala_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_wdata,
	// Sample stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] sample, [15:12] zero
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [11:0] average, [13:12] level,
	                                        // [14] alarm_active, [15] relay_drive,
	                                        // [16] lamp_drive, [17] buzzer_drive,
	                                        // [23:18] zero
);

	cfg_t                cfg_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                valid_s1;
	result_t             res_s2;
	logic                valid_s2;
	logic                adv;
	logic [SAMPLE_W-1:0] average;
	result_t             res;

	// Move stage 1 on when the result register is free or being taken
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = M_TDATA_W'(res_s2);

	// Write configuration registers, masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warning  <= WARNING_RST;
			cfg_q.alert    <= ALERT_RST;
			cfg_q.critical <= CRITICAL_RST;
			cfg_q.enables  <= ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_WARNING:  cfg_q.warning  <= cfg_wdata;
				REG_ALERT:    cfg_q.alert    <= cfg_wdata;
				REG_CRITICAL: cfg_q.critical <= cfg_wdata;
				REG_ENABLES:  cfg_q.enables  <= cfg_wdata[ENABLE_W-1:0];
			endcase
		end
	end

	// Hold the accepted sample in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
		end
	end

	ala_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.sample  (sample_s1),
		.average (average)
	);

	ala_judge u_judge (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.average (average),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Load the result register, drop valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

endmodule

FILE: rtl/ala_checker.sv
// ----------------------------------------------------------------------------
// ala_checker
// Port-level checks of the averaged level alarm, bound to the top level.
// ----------------------------------------------------------------------------
`include "averaged_level_alarm_top_macros.svh"

module ala_checker import ala_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A stalled result beat keeps its payload
	`ALA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Critical level always shows the alarm latched
	`ALA_ASSERT_NOW(a_crit_latch, clk, arst_n, m_tvalid && (m_tdata[13:12] == LVL_CRITICAL), m_tdata[14])

	// Safe level always shows the alarm cleared
	`ALA_ASSERT_NOW(a_safe_clear, clk, arst_n, m_tvalid && (m_tdata[13:12] == LVL_SAFE), !m_tdata[14])

	// Input stays open while no result beat is pending
	`ALA_ASSERT_NOW(a_in_open, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind averaged_level_alarm_top ala_checker u_ala_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/ala_alarm_checker.sv
// ----------------------------------------------------------------------------
// ala_alarm_checker
// Watches the configuration port and both streams of the averaged level
// alarm. Predicts each result beat from the accepted samples and the
// thresholds written so far, and compares it field by field.
// ----------------------------------------------------------------------------
module ala_alarm_checker import ala_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] sample, [15:12] zero
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // [11:0] average, [13:12] level,
	                                        // [14] alarm_active, [15] relay_drive,
	                                        // [16] lamp_drive, [17] buzzer_drive
	output int                   mismatch_count,
	output int                   results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	// Cap on printed mismatch lines; every mismatch is still counted
	localparam int PRINT_CAP = 100;

	// Thresholds and enables as last written
	logic [LEVEL_W-1:0]  warn_q;
	logic [LEVEL_W-1:0]  alert_q;
	logic [LEVEL_W-1:0]  crit_q;
	logic [ENABLE_W-1:0] enables_q;

	// Moving-average ring, latch and drive levels
	logic [SAMPLE_W-1:0] ring_q [RING_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                latch_q;
	logic                relay_q;
	logic                lamp_q;
	logic                buzzer_q;

	result_t alarm_results_due [$];
	result_t got_beat;
	result_t due_beat;
	int      beat_no;

	task automatic report_mismatch(input string what, input int got_v, input int exp_v);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] result beat %0d: %s got %0d expected %0d",
				$time, beat_no, what, got_v, exp_v);
		mismatch_count++;
	endtask

	// Fold one sample into the ring and work out the level and drives
	task automatic predict_alarm_result(input logic [SAMPLE_W-1:0] smp, output result_t res);
		logic [SAMPLE_W-1:0] avg;
		level_t              lvl;
		total_q = total_q - TOTAL_W'(ring_q[slot_q]) + TOTAL_W'(smp);
		ring_q[slot_q] = smp;
		slot_q = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
		avg = SAMPLE_W'(total_q / RING_DEPTH);

		// Critical first, then alert, then warning; latch holds in between
		if (avg >= crit_q) begin
			lvl = LVL_CRITICAL;
			latch_q = 1'b1;
		end else if (avg >= alert_q) begin
			lvl = LVL_ALERT;
		end else if (avg >= warn_q) begin
			lvl = LVL_WARNING;
		end else begin
			lvl = LVL_SAFE;
			latch_q = 1'b0;
		end

		// Drives without their enable bit keep their level
		if (latch_q) begin
			if (enables_q[EN_RELAY])  relay_q = 1'b1;
			if (enables_q[EN_LAMP])   lamp_q = 1'b1;
			if (enables_q[EN_BUZZER]) buzzer_q = (lvl == LVL_CRITICAL) ? 1'b1 : ~buzzer_q;
		end else begin
			if (enables_q[EN_RELAY])  relay_q = 1'b0;
			if (enables_q[EN_LAMP])   lamp_q = 1'b0;
			if (enables_q[EN_BUZZER]) buzzer_q = 1'b0;
		end

		res.average      = avg;
		res.level        = lvl;
		res.alarm_active = latch_q;
		res.relay_drive  = relay_q;
		res.lamp_drive   = lamp_q;
		res.buzzer_drive = buzzer_q;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q    = WARNING_RST;
			alert_q   = ALERT_RST;
			crit_q    = CRITICAL_RST;
			enables_q = ENABLE_RST;
			for (int i = 0; i < RING_DEPTH; i++)
				ring_q[i] = '0;
			slot_q   = '0;
			total_q  = '0;
			latch_q  = 1'b0;
			relay_q  = 1'b0;
			lamp_q   = 1'b0;
			buzzer_q = 1'b0;
			alarm_results_due.delete();
			beat_no = 0;
			results_owed <= 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					REG_WARNING:  warn_q = cfg_wdata;
					REG_ALERT:    alert_q = cfg_wdata;
					REG_CRITICAL: crit_q = cfg_wdata;
					REG_ENABLES:  enables_q = cfg_wdata[ENABLE_W-1:0];
					default: ;
				endcase
			end

			// Compare a result beat with the oldest prediction
			if (m_tvalid && m_tready) begin
				got_beat = m_tdata[$bits(result_t)-1:0];
				if (alarm_results_due.size() == 0) begin
					report_mismatch("beat with nothing due", int'(got_beat), 0);
				end else begin
					due_beat = alarm_results_due.pop_front();
					if (got_beat.average != due_beat.average)
						report_mismatch("average", int'(got_beat.average),
							int'(due_beat.average));
					if (got_beat.level != due_beat.level)
						report_mismatch("level", int'(got_beat.level),
							int'(due_beat.level));
					if (got_beat.alarm_active != due_beat.alarm_active)
						report_mismatch("alarm_active", int'(got_beat.alarm_active),
							int'(due_beat.alarm_active));
					if (got_beat.relay_drive != due_beat.relay_drive)
						report_mismatch("relay_drive", int'(got_beat.relay_drive),
							int'(due_beat.relay_drive));
					if (got_beat.lamp_drive != due_beat.lamp_drive)
						report_mismatch("lamp_drive", int'(got_beat.lamp_drive),
							int'(due_beat.lamp_drive));
					if (got_beat.buzzer_drive != due_beat.buzzer_drive)
						report_mismatch("buzzer_drive", int'(got_beat.buzzer_drive),
							int'(due_beat.buzzer_drive));
				end
				beat_no++;
			end

			// Predict the result of an accepted sample
			if (s_tvalid && s_tready) begin
				predict_alarm_result(s_tdata[SAMPLE_W-1:0], due_beat);
				alarm_results_due.push_back(due_beat);
			end

			results_owed <= alarm_results_due.size();
		end
	end

endmodule

FILE: tb/averaged_level_alarm_top_tb.sv
// ----------------------------------------------------------------------------
// averaged_level_alarm_top_tb
// Drives samples and threshold settings into the averaged level alarm.
// A directed run fills and drains the ring through every level, then random
// bursts around moving targets sweep the average across the thresholds
// under several settings and handshake profiles. The checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module averaged_level_alarm_top_tb;
	import ala_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted beat before the run is abandoned
	localparam int STALL_LIMIT   = 1000;
	localparam int SEGMENTS      = 9;
	localparam int SEGMENT_ITEMS = 100;
	localparam int DRAIN_SETTLE  = 3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = REG_WARNING;
	logic [LEVEL_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;     // [11:0] sample, [15:12] zero
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;          // [11:0] average, [13:12] level,
	                                        // [14] alarm_active, [15] relay_drive,
	                                        // [16] lamp_drive, [17] buzzer_drive

	int mismatch_count;
	int results_owed;
	int send_idle_pct = 32;
	int recv_stall_pct = 67;
	int idle_cycles = 0;
	int samples_sent = 0;
	int settings_applied = 0;
	int burst_left = 0;
	int burst_target = 0;

	always #5ns clk = ~clk;

	averaged_level_alarm_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	ala_alarm_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// Stall the result stream at random
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Abandon the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("No beat accepted for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offer one sample beat, idling first at random, and hold until taken
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, smp};
		do
			@(posedge clk);
		while (!s_tready);
		samples_sent++;
	endtask

	// Hold off until every predicted result has come out
	task automatic wait_results_drained();
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	// Write all four registers on consecutive cycles
	task automatic apply_setting(input logic [LEVEL_W-1:0] warn, input logic [LEVEL_W-1:0] alrt,
			input logic [LEVEL_W-1:0] crit, input logic [LEVEL_W-1:0] en);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WARNING;
		cfg_wdata <= warn;
		@(posedge clk);
		cfg_index <= REG_ALERT;
		cfg_wdata <= alrt;
		@(posedge clk);
		cfg_index <= REG_CRITICAL;
		cfg_wdata <= crit;
		@(posedge clk);
		cfg_index <= REG_ENABLES;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// Bursts of samples around a moving target, with some plain noise
	task automatic next_random_sample(output logic [SAMPLE_W-1:0] smp);
		int val;
		if (burst_left == 0) begin
			burst_left = $urandom_range(20, 4);
			case ($urandom_range(4))
				0:       burst_target = 0;
				1:       burst_target = 4095;
				default: burst_target = $urandom_range(4095);
			endcase
		end
		burst_left--;
		if ($urandom_range(4) == 0) begin
			smp = SAMPLE_W'($urandom_range(4095));
		end else begin
			val = burst_target + int'($urandom_range(600)) - 300;
			if (val < 0)
				val = 0;
			if (val > 4095)
				val = 4095;
			smp = SAMPLE_W'(val);
		end
	endtask

	initial begin
		logic [LEVEL_W-1:0] t0;
		logic [LEVEL_W-1:0] t1;
		logic [LEVEL_W-1:0] t2;
		logic [LEVEL_W-1:0] tmp;
		logic [SAMPLE_W-1:0] smp;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the ring at full scale: warning, alert, then critical
		repeat (RING_DEPTH) send_sample(12'hFFF);
		// Drain it to zero: buzzer toggles through alert and warning, latch clears
		repeat (RING_DEPTH) send_sample(12'h000);
		// Alternate extremes and mid-scale values
		send_sample(12'hFFF);
		send_sample(12'h000);
		send_sample(12'hFFF);
		send_sample(12'h800);
		send_sample(12'h7FF);
		s_tvalid <= 1'b0;

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_results_drained();

			// Swap the idle balance, then run without idling
			if (seg == SEGMENTS / 3) begin
				send_idle_pct  = 67;
				recv_stall_pct = 32;
			end else if (seg == 2 * SEGMENTS / 3) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end

			case (seg)
				0: apply_setting(WARNING_RST, ALERT_RST, CRITICAL_RST, 12'(ENABLE_RST));
				1: apply_setting(12'd0, 12'd0, 12'd0, 12'd7);
				2: apply_setting(12'd4095, 12'd4095, 12'd4095, 12'd0);
				3: apply_setting(12'd3000, 12'd2000, 12'd1000, 12'hFFA);
				4: apply_setting(12'd0, 12'd4095, 12'd4095, 12'h005);
				default: begin
					t0 = LEVEL_W'($urandom_range(4095));
					t1 = LEVEL_W'($urandom_range(4095));
					t2 = LEVEL_W'($urandom_range(4095));
					// Mostly ordered thresholds, sometimes left unordered
					if ($urandom_range(3) != 0) begin
						if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
						if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
						if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
					end
					apply_setting(t0, t1, t2, LEVEL_W'($urandom_range(4095)));
				end
			endcase

			repeat (SEGMENT_ITEMS) begin
				next_random_sample(smp);
				send_sample(smp);
			end
			s_tvalid <= 1'b0;
		end

		wait_results_drained();

		$display("Covered %0d samples under %0d threshold and enable settings,",
			samples_sent, settings_applied);
		$display("with stalls weighted to either side and a stall-free stretch.");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
